[rtl/core/classful_subnet_address_classifier_core_macros.svh]
// Assertion macros for the classful subnet address classifier core.
`ifndef CLASSFUL_SUBNET_ADDRESS_CLASSIFIER_CORE_MACROS_SVH
`define CLASSFUL_SUBNET_ADDRESS_CLASSIFIER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");
`define ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, clk, rst, pre, post)
`define ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

[rtl/core/cscc_pkg.sv]
// Shared types, codes and helpers of the classful subnet address classifier.
`timescale 1ns / 1ps
package cscc_pkg;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_QUERY  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ROUTE_NETWORK = 2'd0,
      ROUTE_SUBNET  = 2'd1,
      ROUTE_HOST    = 2'd2
   } route_kind_type;

   localparam logic [31:0] CLASS_A_MASK = 32'hFF00_0000;
   localparam logic [31:0] CLASS_B_MASK = 32'hFFFF_0000;
   localparam logic [31:0] CLASS_C_MASK = 32'hFFFF_FF00;

   // Query context, broadcast to every cell while a lookup walks the chain.
   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] cmask;
      logic [31:0] cnet;
      logic [31:0] chost;
      logic [31:0] host_bits;
      logic [31:0] peer;
      logic        internal;
   } query_ctx_type;

   // Running lookup result, handed from cell to cell.
   typedef struct packed {
      logic           valid;
      logic           got_net;
      logic           got_make;
      logic           got_kind;
      logic [31:0]    netnum;
      logic [31:0]    hostp;
      logic [31:0]    amask;
      logic [31:0]    hmask;
      route_kind_type kindv;
   } query_tok_type;

   function automatic logic [31:0] class_mask(input logic [31:0] a);
      logic [31:0] m;
      if (!a[31]) begin
         m = CLASS_A_MASK;
      end else if (!a[30]) begin
         m = CLASS_B_MASK;
      end else begin
         m = CLASS_C_MASK;
      end
      return m;
   endfunction

endpackage

[rtl/core/cscc_cell.sv]
// One table entry of the classifier chain: holds an entry and refines a passing lookup.
`timescale 1ns / 1ps
module cscc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    live,
   input  logic                    wr_en,
   input  logic [31:0]             wr_net,
   input  logic [31:0]             wr_netmask,
   input  logic [31:0]             wr_subnet,
   input  cscc_pkg::query_ctx_type ctx,
   input  cscc_pkg::query_tok_type up_tok,
   output cscc_pkg::query_tok_type dn_tok
);

   logic [31:0]             net_ff;
   logic [31:0]             netmask_ff;
   logic [31:0]             subnet_ff;
   cscc_pkg::query_tok_type tok_ff;
   cscc_pkg::query_tok_type tok_in;

   always_comb begin
      tok_in = up_tok;
      if (up_tok.valid && live) begin
         if (!up_tok.got_net && ((netmask_ff & ctx.cnet) == net_ff)) begin
            tok_in.got_net = 1'b1;
            tok_in.netnum  = ctx.addr & subnet_ff;
            tok_in.hostp   = ctx.chost & ~subnet_ff;
         end
         if ((netmask_ff & ctx.addr) == net_ff) begin
            // last match wins for the mask, first match for the host mask
            tok_in.amask = subnet_ff;
            if (!up_tok.got_make) begin
               tok_in.got_make = 1'b1;
               tok_in.hmask    = ~subnet_ff;
            end
         end
         if (!up_tok.got_kind && (ctx.cnet == net_ff)) begin
            tok_in.got_kind = 1'b1;
            if ((ctx.chost & ~subnet_ff) != 32'd0) begin
               tok_in.kindv = cscc_pkg::ROUTE_HOST;
            end else if (subnet_ff != netmask_ff) begin
               tok_in.kindv = cscc_pkg::ROUTE_SUBNET;
            end else begin
               tok_in.kindv = cscc_pkg::ROUTE_NETWORK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         net_ff     <= wr_net;
         netmask_ff <= wr_netmask;
         subnet_ff  <= wr_subnet;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign dn_tok = tok_ff;

endmodule

[rtl/core/classful_subnet_address_classifier_core.sv]
// Classful subnet address classifier: an entry table held in a chain of cells.
// Clear, append and unused commands give their result word one cycle after start.
// A query takes TABLE_ENTRIES + 2 cycles: one to set up, one per cell as the lookup
// walks the chain, one to form the result; busy stays high until then.
// One command at a time; the result strobe lasts one cycle and cannot be stalled.
// Reset clears the entry count and all strobes; table contents are undefined.
`timescale 1ns / 1ps
`include "classful_subnet_address_classifier_core_macros.svh"
module classful_subnet_address_classifier_core #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_address,
   input  logic [31:0] req_host_bits,
   input  logic [31:0] req_peer_address,
   input  logic        req_route_internal,
   input  logic [31:0] req_entry_net,
   input  logic [31:0] req_entry_netmask,
   input  logic [31:0] req_entry_subnetmask,
   output logic        rsp_valid,
   output logic [31:0] rsp_network_number,
   output logic [31:0] rsp_host_part,
   output logic [31:0] rsp_address_mask,
   output logic [31:0] rsp_made_address,
   output logic [1:0]  rsp_route_kind,
   output logic        rsp_send_route,
   output logic        rsp_load_refused
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   cscc_pkg::query_ctx_type ctx_ff;
   cscc_pkg::query_ctx_type ctx_in;
   cscc_pkg::query_tok_type init_ff;
   cscc_pkg::query_tok_type init_in;
   cscc_pkg::query_tok_type tok [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES:0]  tok_vld;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_net_ff, rsp_net_in;
   logic [31:0]             rsp_host_ff, rsp_host_in;
   logic [31:0]             rsp_mask_ff, rsp_mask_in;
   logic [31:0]             rsp_made_ff, rsp_made_in;
   logic [1:0]              rsp_kind_ff, rsp_kind_in;
   logic                    rsp_send_ff, rsp_send_in;
   logic                    rsp_refused_ff, rsp_refused_in;

   logic                    accept;
   logic                    full;
   logic                    append_ok;
   logic [31:0]             q_cmask;
   logic [31:0]             q_cnet;
   logic [31:0]             q_chost;
   logic                    same_net;
   logic                    has_host;
   cscc_pkg::query_tok_type last;

   assign busy      = |tok_vld;
   assign accept    = start && !busy;
   assign full      = (count_ff == CNT_W'(TABLE_ENTRIES));
   assign append_ok = accept && (req_kind == cscc_pkg::KIND_APPEND) && !full;

   assign q_cmask = cscc_pkg::class_mask(req_address);
   assign q_cnet  = req_address & q_cmask;
   assign q_chost = req_address & ~q_cmask;

   assign tok[0] = init_ff;
   assign last   = tok[TABLE_ENTRIES];

   genvar gi;
   generate
      for (gi = 0; gi <= TABLE_ENTRIES; gi++) begin : g_vld
         assign tok_vld[gi] = tok[gi].valid;
      end
      for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
         cscc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .live       (CNT_W'(gi) < count_ff),
            .wr_en      (append_ok && (count_ff == CNT_W'(gi))),
            .wr_net     (req_entry_net),
            .wr_netmask (req_entry_netmask),
            .wr_subnet  (req_entry_subnetmask),
            .ctx        (ctx_ff),
            .up_tok     (tok[gi]),
            .dn_tok     (tok[gi+1])
         );
      end
   endgenerate

   assign same_net = (ctx_ff.cnet == (ctx_ff.peer & ctx_ff.cmask));
   assign has_host = (ctx_ff.chost != 32'd0);

   always_comb begin
      count_in       = count_ff;
      ctx_in         = ctx_ff;
      init_in        = init_ff;
      init_in.valid  = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_net_in     = 32'd0;
      rsp_host_in    = 32'd0;
      rsp_mask_in    = 32'd0;
      rsp_made_in    = 32'd0;
      rsp_kind_in    = 2'd0;
      rsp_send_in    = 1'b0;
      rsp_refused_in = 1'b0;

      if (accept) begin
         unique case (cscc_pkg::kind_type'(req_kind))
            cscc_pkg::KIND_CLEAR: begin
               count_in     = '0;
               rsp_valid_in = 1'b1;
            end
            cscc_pkg::KIND_APPEND: begin
               rsp_valid_in = 1'b1;
               if (full) begin
                  rsp_refused_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            cscc_pkg::KIND_QUERY: begin
               ctx_in.addr      = req_address;
               ctx_in.cmask     = q_cmask;
               ctx_in.cnet      = q_cnet;
               ctx_in.chost     = q_chost;
               ctx_in.host_bits = req_host_bits;
               ctx_in.peer      = req_peer_address;
               ctx_in.internal  = req_route_internal;
               init_in.valid    = 1'b1;
               init_in.got_net  = 1'b0;
               init_in.got_make = 1'b0;
               init_in.got_kind = 1'b0;
               init_in.netnum   = q_cnet;
               init_in.hostp    = q_chost;
               init_in.amask    = (req_address == 32'd0) ? 32'd0 : q_cmask;
               init_in.hmask    = ~q_cmask;
               init_in.kindv    = (q_chost == 32'd0) ? cscc_pkg::ROUTE_NETWORK
                                                     : cscc_pkg::ROUTE_HOST;
            end
            default: begin
               // unused code: zero word, no state change
               rsp_valid_in = 1'b1;
            end
         endcase
      end

      if (last.valid) begin
         rsp_valid_in = 1'b1;
         rsp_net_in   = last.netnum;
         rsp_host_in  = last.hostp;
         rsp_mask_in  = last.amask;
         rsp_made_in  = ctx_ff.addr | (ctx_ff.host_bits & last.hmask);
         rsp_kind_in  = last.kindv;
         rsp_send_in  = same_net ? (has_host || !ctx_ff.internal)
                                 : (!has_host && ctx_ff.internal);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         init_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff     <= count_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff         <= ctx_in;
      rsp_net_ff     <= rsp_net_in;
      rsp_host_ff    <= rsp_host_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_made_ff    <= rsp_made_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_send_ff    <= rsp_send_in;
      rsp_refused_ff <= rsp_refused_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_network_number = rsp_net_ff;
   assign rsp_host_part      = rsp_host_ff;
   assign rsp_address_mask   = rsp_mask_ff;
   assign rsp_made_address   = rsp_made_ff;
   assign rsp_route_kind     = rsp_kind_ff;
   assign rsp_send_route     = rsp_send_ff;
   assign rsp_load_refused   = rsp_refused_ff;

   `ASSERT_NXT(a_query_holds_busy, clock, reset, accept && (req_kind == cscc_pkg::KIND_QUERY), busy)
   `ASSERT_IMP(a_single_lookup, clock, reset, 1'b1, $onehot0(tok_vld))
   `ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_ENTRIES))
   `ASSERT_IMP(a_idle_on_result, clock, reset, rsp_valid, !busy)

endmodule

[tb/sv/classful_subnet_address_classifier_core_tb.sv]
// Self-checking testbench for the classful subnet address classifier core.
`timescale 1ns / 1ps
module classful_subnet_address_classifier_core_tb;

   localparam int          N_ENTRIES   = 8;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          RAND_WORDS  = 1500;
   localparam logic [1:0]  KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] addr;
      logic [31:0] host_bits;
      logic [31:0] peer;
      logic        internal;
      logic [31:0] enet;
      logic [31:0] emask;
      logic [31:0] esub;
   } cmd_word_type;

   typedef struct packed {
      logic [31:0] net_num;
      logic [31:0] host_part;
      logic [31:0] addr_mask;
      logic [31:0] made_addr;
      logic [1:0]  route_kind;
      logic        send_route;
      logic        load_refused;
   } route_word_type;

   typedef struct packed {
      cmd_word_type   cmd;
      logic           lit_valid;
      route_word_type lit;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [31:0] req_address;
   logic [31:0] req_host_bits;
   logic [31:0] req_peer_address;
   logic        req_route_internal;
   logic [31:0] req_entry_net;
   logic [31:0] req_entry_netmask;
   logic [31:0] req_entry_subnetmask;
   logic        rsp_valid;
   logic [31:0] rsp_network_number;
   logic [31:0] rsp_host_part;
   logic [31:0] rsp_address_mask;
   logic [31:0] rsp_made_address;
   logic [1:0]  rsp_route_kind;
   logic        rsp_send_route;
   logic        rsp_load_refused;

   // Shadow copy of the interface table
   logic [31:0] ent_net  [N_ENTRIES];
   logic [31:0] ent_mask [N_ENTRIES];
   logic [31:0] ent_sub  [N_ENTRIES];
   int          ent_used;

   route_word_type pending_routes[$];
   dir_row_type    dir_rows[$];
   int             idle_pct;
   int             err_count;
   int             cycle_count;

   classful_subnet_address_classifier_core #(
      .TABLE_ENTRIES(N_ENTRIES)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_kind             (req_kind),
      .req_address          (req_address),
      .req_host_bits        (req_host_bits),
      .req_peer_address     (req_peer_address),
      .req_route_internal   (req_route_internal),
      .req_entry_net        (req_entry_net),
      .req_entry_netmask    (req_entry_netmask),
      .req_entry_subnetmask (req_entry_subnetmask),
      .rsp_valid            (rsp_valid),
      .rsp_network_number   (rsp_network_number),
      .rsp_host_part        (rsp_host_part),
      .rsp_address_mask     (rsp_address_mask),
      .rsp_made_address     (rsp_made_address),
      .rsp_route_kind       (rsp_route_kind),
      .rsp_send_route       (rsp_send_route),
      .rsp_load_refused     (rsp_load_refused)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] class_mask_of(input logic [31:0] a);
      logic [31:0] m;
      casez (a[31:30])
         2'b0?:   m = cscc_pkg::CLASS_A_MASK;
         2'b10:   m = cscc_pkg::CLASS_B_MASK;
         default: m = cscc_pkg::CLASS_C_MASK;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] prefix_mask(input int len);
      return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
   endfunction

   // Apply one word to the shadow table and return the route word it yields.
   function automatic route_word_type classify_word(input cmd_word_type c);
      route_word_type r;
      logic [31:0]    cmask, cnet, chost, hmask;
      logic           got_net, got_make, got_kind;
      r = '0;
      if (c.kind == cscc_pkg::KIND_CLEAR) begin
         ent_used = 0;
      end else if (c.kind == cscc_pkg::KIND_APPEND) begin
         if (ent_used < N_ENTRIES) begin
            ent_net[ent_used]  = c.enet;
            ent_mask[ent_used] = c.emask;
            ent_sub[ent_used]  = c.esub;
            ent_used++;
         end else begin
            r.load_refused = 1'b1;
         end
      end else if (c.kind == cscc_pkg::KIND_QUERY) begin
         cmask       = class_mask_of(c.addr);
         cnet        = c.addr & cmask;
         chost       = c.addr & ~cmask;
         r.net_num   = cnet;
         r.host_part = chost;
         r.addr_mask = (c.addr == 32'h0) ? 32'h0 : cmask;
         hmask       = ~cmask;
         r.route_kind = (chost == 32'h0) ? cscc_pkg::ROUTE_NETWORK : cscc_pkg::ROUTE_HOST;
         got_net  = 1'b0;
         got_make = 1'b0;
         got_kind = 1'b0;
         for (int i = 0; i < ent_used; i++) begin
            if (!got_net && (ent_mask[i] & cnet) == ent_net[i]) begin
               got_net     = 1'b1;
               r.net_num   = c.addr & ent_sub[i];
               r.host_part = chost & ~ent_sub[i];
            end
            if ((ent_mask[i] & c.addr) == ent_net[i]) begin
               // mask lookup keeps the last hit, address building the first
               r.addr_mask = ent_sub[i];
               if (!got_make) begin
                  got_make = 1'b1;
                  hmask    = ~ent_sub[i];
               end
            end
            if (!got_kind && cnet == ent_net[i]) begin
               got_kind = 1'b1;
               if ((chost & ~ent_sub[i]) != 32'h0) begin
                  r.route_kind = cscc_pkg::ROUTE_HOST;
               end else if (ent_sub[i] != ent_mask[i]) begin
                  r.route_kind = cscc_pkg::ROUTE_SUBNET;
               end else begin
                  r.route_kind = cscc_pkg::ROUTE_NETWORK;
               end
            end
         end
         if (cnet == (c.peer & cmask)) begin
            r.send_route = (chost != 32'h0) ? 1'b1 : !c.internal;
         end else begin
            r.send_route = (chost != 32'h0) ? 1'b0 : c.internal;
         end
         r.made_addr = c.addr | (c.host_bits & hmask);
      end
      return r;
   endfunction

   // Drive one word at the falling edge and hold it until accepted.
   task automatic issue_word(input cmd_word_type c, input logic lit_valid,
                             input route_word_type lit);
      route_word_type want;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start                <= 1'b1;
      req_kind             <= c.kind;
      req_address          <= c.addr;
      req_host_bits        <= c.host_bits;
      req_peer_address     <= c.peer;
      req_route_internal   <= c.internal;
      req_entry_net        <= c.enet;
      req_entry_netmask    <= c.emask;
      req_entry_subnetmask <= c.esub;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = classify_word(c);
      pending_routes.push_back(lit_valid ? lit : want);
   endtask

   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(7))
         0:       w = 32'h0;
         1:       w = 32'hFFFF_FFFF;
         2:       w = 32'h1 << $urandom_range(31);
         3:       w = ~(32'h1 << $urandom_range(31));
         default: w = $urandom;
      endcase
      return w;
   endfunction

   function automatic cmd_word_type random_word();
      cmd_word_type c;
      int           sel, idx, plen;
      logic [31:0]  cm;
      c.kind      = cscc_pkg::KIND_QUERY;
      c.addr      = pick_word();
      c.host_bits = pick_word();
      c.peer      = pick_word();
      c.internal  = 1'($urandom_range(1));
      c.enet      = $urandom;
      c.emask     = $urandom;
      c.esub      = $urandom;
      sel = $urandom_range(99);
      if (sel < 2) begin
         c.kind = cscc_pkg::KIND_CLEAR;
      end else if (sel < 16) begin
         c.kind = cscc_pkg::KIND_APPEND;
         if ($urandom_range(99) >= 15) begin
            // well-formed classful entry with a subnet prefix at least as long as the class prefix
            case ($urandom_range(2))
               0: begin
                  c.emask = cscc_pkg::CLASS_A_MASK;
                  plen = 8;
                  c.enet = {1'b0, 31'($urandom)} & cscc_pkg::CLASS_A_MASK;
               end
               1: begin
                  c.emask = cscc_pkg::CLASS_B_MASK;
                  plen = 16;
                  c.enet = {2'b10, 30'($urandom)} & cscc_pkg::CLASS_B_MASK;
               end
               default: begin
                  c.emask = cscc_pkg::CLASS_C_MASK;
                  plen = 24;
                  c.enet = {2'b11, 30'($urandom)} & cscc_pkg::CLASS_C_MASK;
               end
            endcase
            c.esub = prefix_mask($urandom_range(32, plen));
         end
      end else if (sel < 18) begin
         c.kind = KIND_UNUSED;
      end else begin
         if (ent_used > 0 && $urandom_range(99) < 65) begin
            idx = $urandom_range(ent_used - 1);
            c.addr = ent_net[idx] | ($urandom & ~ent_mask[idx]);
            if ($urandom_range(99) < 30) c.addr = c.addr & ent_sub[idx];
         end
         if ($urandom_range(1) == 1) begin
            cm = class_mask_of(c.addr);
            c.peer = (c.addr & cm) | ($urandom & ~cm);
         end
      end
      return c;
   endfunction

   // Compare every result word against the oldest expectation
   always @(posedge clock) begin
      route_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_routes.size() == 0) begin
            $error("result word with nothing expected");
            err_count++;
         end else begin
            want = pending_routes.pop_front();
            if (rsp_network_number !== want.net_num) begin
               $error("network_number: expected %h, got %h", want.net_num,
                      rsp_network_number);
               err_count++;
            end
            if (rsp_host_part !== want.host_part) begin
               $error("host_part: expected %h, got %h", want.host_part, rsp_host_part);
               err_count++;
            end
            if (rsp_address_mask !== want.addr_mask) begin
               $error("address_mask: expected %h, got %h", want.addr_mask,
                      rsp_address_mask);
               err_count++;
            end
            if (rsp_made_address !== want.made_addr) begin
               $error("made_address: expected %h, got %h", want.made_addr,
                      rsp_made_address);
               err_count++;
            end
            if (rsp_route_kind !== want.route_kind) begin
               $error("route_kind: expected %0d, got %0d", want.route_kind,
                      rsp_route_kind);
               err_count++;
            end
            if (rsp_send_route !== want.send_route) begin
               $error("send_route: expected %0d, got %0d", want.send_route,
                      rsp_send_route);
               err_count++;
            end
            if (rsp_load_refused !== want.load_refused) begin
               $error("load_refused: expected %0d, got %0d", want.load_refused,
                      rsp_load_refused);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** classful_subnet_address_classifier_core: FAILED **");
         $finish;
      end
   end

   initial begin
      route_word_type no_lit;
      int             phase_idle[4];
      no_lit      = '0;
      err_count   = 0;
      cycle_count = 0;
      ent_used    = 0;
      idle_pct    = 0;
      phase_idle  = '{0, 66, 24, 0};
      reset                <= 1'b1;
      start                <= 1'b0;
      req_kind             <= cscc_pkg::KIND_CLEAR;
      req_address          <= '0;
      req_host_bits        <= '0;
      req_peer_address     <= '0;
      req_route_internal   <= 1'b0;
      req_entry_net        <= '0;
      req_entry_netmask    <= '0;
      req_entry_subnetmask <= '0;

      // classful extremes on an empty table
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0,
         32'h0, 32'h0}, 1'b1,
         '{32'h0, 32'h0, 32'h0, 32'h0, cscc_pkg::ROUTE_NETWORK, 1'b1, 1'b0}});
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
         1'b1, 32'h0, 32'h0, 32'h0}, 1'b1, '{32'hFFFF_FF00, 32'h0000_00FF,
         32'hFFFF_FF00, 32'hFFFF_FFFF, cscc_pkg::ROUTE_HOST, 1'b0, 1'b0}});
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'h8000_0000, 32'h0, 32'h8000_1234,
         1'b1, 32'h0, 32'h0, 32'h0}, 1'b1, '{32'h8000_0000, 32'h0, 32'hFFFF_0000,
         32'h8000_0000, cscc_pkg::ROUTE_NETWORK, 1'b0, 1'b0}});
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'h7FFF_FFFF, 32'h0, 32'hC000_0000,
         1'b0, 32'h0, 32'h0, 32'h0}, 1'b1, '{32'h7F00_0000, 32'h00FF_FFFF,
         32'hFF00_0000, 32'h7FFF_FFFF, cscc_pkg::ROUTE_HOST, 1'b0, 1'b0}});
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'h0A00_0000, 32'h0, 32'h0B00_0000,
         1'b1, 32'h0, 32'h0, 32'h0}, 1'b1, '{32'h0A00_0000, 32'h0, 32'hFF00_0000,
         32'h0A00_0000, cscc_pkg::ROUTE_NETWORK, 1'b1, 1'b0}});
      // unused code and clear give an all-zero word
      dir_rows.push_back('{'{KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_CLEAR, 32'h1234_5678, 32'h0, 32'h0, 1'b1,
         32'h0, 32'h0, 32'h0}, 1'b1, no_lit});
      // subnetted class A, then host and subnet routes, and a class B network route
      dir_rows.push_back('{'{cscc_pkg::KIND_APPEND, 32'h0, 32'h0, 32'h0, 1'b0,
         32'h0A00_0000, 32'hFF00_0000, 32'hFFFF_0000}, 1'b1, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'h0A01_0203, 32'hFFFF_FFFF,
         32'h0A00_00FF, 1'b0, 32'h0, 32'h0, 32'h0}, 1'b0, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'h0A01_0000, 32'h0, 32'h0, 1'b1,
         32'h0, 32'h0, 32'h0}, 1'b0, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_APPEND, 32'h0, 32'h0, 32'h0, 1'b0,
         32'h8001_0000, 32'hFFFF_0000, 32'hFFFF_0000}, 1'b1, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'h8001_0000, 32'h1234_5678,
         32'h8001_0001, 1'b0, 32'h0, 32'h0, 32'h0}, 1'b0, no_lit});
      // overlapping entry: mask lookup must pick the later one
      dir_rows.push_back('{'{cscc_pkg::KIND_APPEND, 32'h0, 32'h0, 32'h0, 1'b0,
         32'h0A00_0000, 32'hFF00_0000, 32'hFFFF_FF00}, 1'b1, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'h0A01_02FF, 32'hFFFF_FFFF, 32'h0,
         1'b0, 32'h0, 32'h0, 32'h0}, 1'b0, no_lit});
      // fill the table
      dir_rows.push_back('{'{cscc_pkg::KIND_APPEND, 32'h0, 32'h0, 32'h0, 1'b0,
         32'hC0A8_0100, 32'hFFFF_FF00, 32'hFFFF_FFC0}, 1'b1, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_APPEND, 32'h0, 32'h0, 32'h0, 1'b0,
         32'hAC10_0000, 32'hFFFF_0000, 32'hFFFF_FF00}, 1'b1, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_APPEND, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0,
         32'h0, 32'h0}, 1'b1, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_APPEND, 32'h0, 32'h0, 32'h0, 1'b0,
         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_APPEND, 32'h0, 32'h0, 32'h0, 1'b0,
         32'h7F00_0000, 32'hFF00_0000, 32'hFF00_0000}, 1'b1, no_lit});
      // append to a full table is refused
      dir_rows.push_back('{'{cscc_pkg::KIND_APPEND, 32'h0, 32'h0, 32'h0, 1'b1,
         32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
         '{32'h0, 32'h0, 32'h0, 32'h0, cscc_pkg::ROUTE_NETWORK, 1'b0, 1'b1}});
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'hC0A8_0142, 32'hFFFF_FFFF,
         32'hC0A8_0100, 1'b1, 32'h0, 32'h0, 32'h0}, 1'b0, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_CLEAR, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0,
         32'h0, 32'h0}, 1'b1, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'h0A01_0203, 32'hFFFF_FFFF, 32'h0,
         1'b0, 32'h0, 32'h0, 32'h0}, 1'b0, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_APPEND, 32'h0, 32'h0, 32'h0, 1'b0,
         32'hC000_0000, 32'hFFFF_FF00, 32'hFFFF_FF00}, 1'b1, no_lit});
      dir_rows.push_back('{'{cscc_pkg::KIND_QUERY, 32'hC000_0000, 32'h0, 32'hC000_0005,
         1'b1, 32'h0, 32'h0, 32'h0}, 1'b0, no_lit});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         issue_word(dir_rows[i].cmd, dir_rows[i].lit_valid, dir_rows[i].lit);
      end

      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_idle[p];
         for (int n = 0; n < RAND_WORDS / 4; n++) begin
            issue_word(random_word(), 1'b0, no_lit);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
      repeat (N_ENTRIES + 4) @(posedge clock);

      if (err_count == 0) begin
         $display("** classful_subnet_address_classifier_core: PASSED **");
      end else begin
         $display("** classful_subnet_address_classifier_core: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/cscc_pkg.sv
rtl/core/cscc_cell.sv
rtl/core/classful_subnet_address_classifier_core.sv
tb/sv/classful_subnet_address_classifier_core_tb.sv
